[rtl/cdt_pkg.sv]
// Shared types, constants and base-60 arithmetic helpers for the countdown timer.
`default_nettype none

package cdt_pkg;

    localparam int TIME_BITS    = 32;
    localparam int TGT_BITS     = 12;
    localparam int DIGIT_BITS   = 6;
    localparam int BASE60       = 60;

    localparam int DEFAULT_TARGET = 300;
    localparam int DEFAULT_MIN    = (DEFAULT_TARGET / BASE60) % BASE60;
    localparam int DEFAULT_SEC    = DEFAULT_TARGET % BASE60;

    // reciprocal of 60 scaled by 2^18, exact for 12-bit dividends
    localparam int RECIP60_SHIFT12 = 18;
    localparam int RECIP60_MUL12   = (1 << RECIP60_SHIFT12) / BASE60 + 1;
    // reciprocal of 60 scaled by 2^20, exact for 14-bit dividends
    localparam int RECIP60_SHIFT14 = 20;
    localparam int RECIP60_MUL14   = (1 << RECIP60_SHIFT14) / BASE60 + 1;

    // offset-binary bias: signed delta d = u - 2^31, and -2^31 mod 60
    localparam int ENC_BIAS = BASE60 - int'(64'd2147483648 % 64'd60);

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [TGT_BITS-1:0]   tgt_t;
    typedef logic [DIGIT_BITS-1:0] digit_t;

    typedef struct packed {
        logic               double_click;
        logic               single_click;
        logic [31:0]        now_seconds;
        logic               first_half;
        logic signed [31:0] encoder_count;
    } poll_t;

    typedef struct packed {
        logic [5:0] minute_digit;
        logic [5:0] second_digit;
        logic       show_colon;
        logic       display_changed;
        logic       in_set_mode;
        logic       editing_minutes;
        logic       countdown_paused;
        logic       buzz_click;
        logic       buzz_done;
        logic       vib_mode_switch;
        logic       vib_step;
        logic       vib_done;
    } status_t;

    // floor(x / 60) for a 12-bit value; result at most 68
    function automatic logic [6:0] quot60(input tgt_t x);
        logic [24:0] p;
        p = 25'(x) * 25'(RECIP60_MUL12);
        return p[24:18];
    endfunction

    // x - 60*q for a 12-bit value and its quotient
    function automatic digit_t rem60(input tgt_t x, input logic [6:0] q);
        logic [12:0] prod;
        prod = ({6'b0, q} << 6) - ({6'b0, q} << 2);
        return DIGIT_BITS'(x - prod[11:0]);
    endfunction

    // q mod 60 for q below 120
    function automatic digit_t wrap60(input logic [6:0] q);
        logic [6:0] t;
        t = (q >= 7'(BASE60)) ? q - 7'(BASE60) : q;
        return DIGIT_BITS'(t);
    endfunction

    // x mod 60 for a 14-bit value
    function automatic digit_t mod60_14(input logic [13:0] x);
        logic [28:0] p;
        logic [8:0]  q;
        logic [13:0] prod;
        p    = 29'(x) * 29'(RECIP60_MUL14);
        q    = p[28:20];
        prod = 14'({q, 6'b0}) - 14'({q, 2'b0});
        return DIGIT_BITS'(x - prod);
    endfunction

    // (base + signed delta) mod 60, floor convention; 256^k = 16 (mod 60)
    function automatic digit_t add_mod60(input digit_t base, input logic [31:0] delta);
        logic [31:0] u;
        logic [9:0]  hi;
        logic [13:0] sum;
        u   = delta ^ 32'h8000_0000;
        hi  = 10'(u[15:8]) + 10'(u[23:16]) + 10'(u[31:24]);
        sum = {hi, 4'b0} + 14'(u[7:0]) + 14'(base) + 14'(ENC_BIAS);
        return mod60_14(sum);
    endfunction

endpackage

`default_nettype wire

[rtl/cdt_poll_if.sv]
// Poll channel interface: valid/ready with one poll item.
`default_nettype none

interface cdt_poll_if
    import cdt_pkg::*;
();
    logic  valid;
    logic  ready;
    poll_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cdt_status_if.sv]
// Status channel interface: valid/ready with one display/status item.
`default_nettype none

interface cdt_status_if
    import cdt_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cdt_core.sv]
// Timer state registers and the per-poll next-state and status logic.
`default_nettype none

module cdt_core
    import cdt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_we,
    input  wire tgt_t    cfg_wdata,
    input  wire logic    step,
    input  wire poll_t   item,
    output status_t      res
);

    logic        set_reg, set_next;
    tgt_t        tgt_reg, tgt_next;
    digit_t      mv_reg, mv_next;
    digit_t      sv_reg, sv_next;
    logic        col_reg, col_next;
    logic        pau_reg, pau_next;
    logic        fr_reg, fr_next;
    time_t       rb_reg, rb_next;
    time_t       ps_reg, ps_next;
    logic        em_reg, em_next;
    digit_t      ebm_reg, ebm_next;
    digit_t      ebs_reg, ebs_next;
    logic [31:0] encb_reg, encb_next;
    logic        tv_reg, tv_next;

    time_t       now_t;
    time_t       elapsed;
    tgt_t        remain;
    logic [6:0]  tgt_q, rem_q;
    digit_t      tgt_min, tgt_sec, rem_sec, rem_min, edit_val;
    logic [31:0] enc;
    logic        dbl, clk_ev;
    logic        changed, bclick, bdone, vstep;

    always_comb
    begin
        now_t   = TIME_BITS'(item.now_seconds);
        enc     = $unsigned(item.encoder_count);
        dbl     = item.double_click;
        clk_ev  = item.single_click;

        tgt_q   = quot60(tgt_reg);
        tgt_min = wrap60(tgt_q);
        tgt_sec = rem60(tgt_reg, tgt_q);

        set_next  = set_reg;
        tgt_next  = tgt_reg;
        mv_next   = mv_reg;
        sv_next   = sv_reg;
        col_next  = col_reg;
        pau_next  = pau_reg;
        fr_next   = fr_reg;
        rb_next   = rb_reg;
        ps_next   = ps_reg;
        em_next   = em_reg;
        ebm_next  = ebm_reg;
        ebs_next  = ebs_reg;
        encb_next = encb_reg;
        tv_next   = tv_reg;
        changed   = 1'b0;
        bclick    = 1'b0;
        bdone     = 1'b0;
        vstep     = 1'b0;
        elapsed   = '0;
        remain    = '0;
        rem_q     = '0;
        rem_sec   = '0;
        rem_min   = '0;
        edit_val  = '0;

        if (!tv_reg)
        begin
            rb_next = now_t;
            ps_next = now_t;
            tv_next = 1'b1;
        end

        if (dbl)
        begin
            set_next = !set_reg;
            changed  = 1'b1;
            if (set_reg)
            begin
                // commit edited digits; the new target's digits are mv/sv themselves
                tgt_next = TGT_BITS'(TGT_BITS'(mv_reg) * TGT_BITS'(BASE60))
                         + TGT_BITS'(sv_reg);
                fr_next  = 1'b1;
                col_next = 1'b1;
                rb_next  = now_t;
                ps_next  = now_t;
                pau_next = 1'b1;
            end
            else
            begin
                em_next   = 1'b1;
                mv_next   = tgt_min;
                sv_next   = tgt_sec;
                fr_next   = 1'b1;
                col_next  = 1'b0;
                ebm_next  = tgt_min;
                ebs_next  = tgt_sec;
                encb_next = enc;
            end
        end

        if (!set_next)
        begin
            if (clk_ev)
            begin
                pau_next = !pau_next;
                if (pau_next)
                    ps_next = now_t;
                else
                    rb_next = rb_next + (now_t - ps_next);
                bclick = 1'b1;
            end

            if (!(pau_next && !fr_next))
            begin
                if (!tv_reg || dbl)
                    elapsed = '0;
                else if (clk_ev && !pau_next)
                    elapsed = ps_reg - rb_reg;
                else
                    elapsed = now_t - rb_reg;

                if (fr_next || (item.first_half != col_next))
                begin
                    col_next = item.first_half;
                    changed  = 1'b1;
                end

                remain  = tgt_reg - elapsed[TGT_BITS-1:0];
                rem_q   = quot60(remain);
                rem_sec = rem60(remain, rem_q);
                rem_min = wrap60(rem_q);

                if (elapsed > TIME_BITS'(tgt_reg))
                begin
                    bdone    = 1'b1;
                    fr_next  = 1'b1;
                    col_next = 1'b1;
                    mv_next  = tgt_min;
                    sv_next  = tgt_sec;
                    rb_next  = now_t;
                    ps_next  = now_t;
                    pau_next = 1'b1;
                end
                else
                begin
                    // after a commit the digits already match the new target
                    if (!dbl && (fr_next || rem_sec != sv_reg))
                    begin
                        sv_next = rem_sec;
                        if (fr_next || rem_sec == DIGIT_BITS'(BASE60 - 1))
                            mv_next = rem_min;
                    end
                    fr_next = 1'b0;
                end
            end
        end
        else
        begin
            if (clk_ev)
            begin
                em_next   = !em_next;
                fr_next   = 1'b1;
                col_next  = 1'b0;
                ebm_next  = mv_next;
                ebs_next  = sv_next;
                encb_next = enc;
                bclick    = 1'b1;
            end

            // a fresh encoder base gives zero delta, so no step on those polls
            edit_val = add_mod60(em_reg ? ebm_reg : ebs_reg, enc - encb_reg);
            if (!dbl && !clk_ev)
            begin
                if (em_reg)
                begin
                    if (edit_val != mv_reg)
                    begin
                        mv_next = edit_val;
                        changed = 1'b1;
                        vstep   = 1'b1;
                    end
                end
                else if (edit_val != sv_reg)
                begin
                    sv_next = edit_val;
                    changed = 1'b1;
                    vstep   = 1'b1;
                end
            end
            fr_next = 1'b0;
        end

        res.minute_digit     = mv_next;
        res.second_digit     = sv_next;
        res.show_colon       = col_next;
        res.display_changed  = changed;
        res.in_set_mode      = set_next;
        res.editing_minutes  = set_next & em_next;
        res.countdown_paused = pau_next;
        res.buzz_click       = bclick;
        res.buzz_done        = bdone;
        res.vib_mode_switch  = dbl;
        res.vib_step         = vstep;
        res.vib_done         = bdone;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg  <= 1'b0;
            tgt_reg  <= TGT_BITS'(DEFAULT_TARGET);
            mv_reg   <= DIGIT_BITS'(DEFAULT_MIN);
            sv_reg   <= DIGIT_BITS'(DEFAULT_SEC);
            col_reg  <= 1'b1;
            pau_reg  <= 1'b1;
            fr_reg   <= 1'b1;
            rb_reg   <= '0;
            ps_reg   <= '0;
            em_reg   <= 1'b1;
            ebm_reg  <= '0;
            ebs_reg  <= '0;
            encb_reg <= '0;
            tv_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            // in display mode, display digits get reloaded by the forced refresh on the next poll
            tgt_reg <= cfg_wdata;
            if (!set_reg)
                fr_reg <= 1'b1;
        end
        else if (step)
        begin
            set_reg  <= set_next;
            tgt_reg  <= tgt_next;
            mv_reg   <= mv_next;
            sv_reg   <= sv_next;
            col_reg  <= col_next;
            pau_reg  <= pau_next;
            fr_reg   <= fr_next;
            rb_reg   <= rb_next;
            ps_reg   <= ps_next;
            em_reg   <= em_next;
            ebm_reg  <= ebm_next;
            ebs_reg  <= ebs_next;
            encb_reg <= encb_next;
            tv_reg   <= tv_next;
        end
    end

endmodule

`default_nettype wire

[rtl/countdown_timer_mm_ss_top.sv]
// Top level of the minutes:seconds countdown timer: poll register, core, status register.
//
//  channel    dir   handshake          payload
//  poll       in    valid/ready        clicks, now_seconds, first_half, encoder_count
//  status     out   valid/ready        digits, colon, mode and pulse flags
//  cfg        in    cfg_we             cfg_wdata = default_target_seconds
//
//  One poll per cycle while status.ready holds; each poll goes via the poll and status registers.
//  The poll register feeds the core, whose state and result update in the same cycle.
//  Reset: display mode, paused, 300 s target; first poll sets the time base.
//  A stalled status register holds the poll register; poll.ready drops only when both are full.
`default_nettype none

module countdown_timer_mm_ss_top
    import cdt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    cdt_poll_if.sink      poll,
    cdt_status_if.source  status,
    input  wire logic     cfg_we,
    input  wire tgt_t     cfg_wdata
);

    logic    in_v_reg, in_v_next;
    poll_t   in_d_reg;
    logic    out_v_reg, out_v_next;
    status_t out_d_reg;
    status_t res;
    logic    adv;

    assign adv        = in_v_reg && (!out_v_reg || status.ready);
    assign poll.ready = !in_v_reg || adv;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (poll.valid && poll.ready)
            in_v_next = 1'b1;
        else if (adv)
            in_v_next = 1'b0;

        out_v_next = out_v_reg;
        if (adv)
            out_v_next = 1'b1;
        else if (status.ready)
            out_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
            in_d_reg <= poll.data;
        if (adv)
            out_d_reg <= res;
    end

    cdt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (adv),
        .item      (in_d_reg),
        .res       (res)
    );

    assign status.valid = out_v_reg;
    assign status.data  = out_d_reg;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && out_v_reg && !status.ready |-> !poll.ready)
        else $error("poll accepted while both stages are full");

    a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(in_v_reg))
        else $error("status produced without a held poll");

    a_done_paused: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_d_reg.buzz_done |->
            out_d_reg.countdown_paused && !out_d_reg.in_set_mode)
        else $error("expiry must reload paused in display mode");

    a_step_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_d_reg.vib_step |-> out_d_reg.in_set_mode && out_d_reg.display_changed)
        else $error("set step outside set mode");
`endif

endmodule

`default_nettype wire
